// File: src/tmls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker mode and LED sequencer package
// Shared types, mode and register codes and timing constants.
// ----------------------------------------------------------------------------
package tmls_pkg;

    // Operating modes.
    localparam logic [2:0] MODE_INIT    = 3'd0;
    localparam logic [2:0] MODE_PAIRING = 3'd1;
    localparam logic [2:0] MODE_SYNCING = 3'd2;
    localparam logic [2:0] MODE_RUNNING = 3'd3;
    localparam logic [2:0] MODE_SLEEP   = 3'd4;
    localparam logic [2:0] MODE_WAKEUP  = 3'd5;
    localparam logic [2:0] MODE_ERROR   = 3'd6;

    // Radio sync report codes.
    localparam logic [1:0] SYNC_LOST   = 2'd1;
    localparam logic [1:0] SYNC_GAINED = 2'd2;

    // Peripheral init status codes.
    localparam logic [1:0] INIT_OK          = 2'd0;
    localparam logic [1:0] INIT_SENSOR_FAIL = 2'd1;

    // Configuration register indexes.
    localparam logic [2:0] REG_STORED_PAIR_ID   = 3'd0;
    localparam logic [2:0] REG_PAIRING_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_SYNC_TIMEOUT     = 3'd2;
    localparam logic [2:0] REG_SLEEP_TIMEOUT    = 3'd3;
    localparam logic [2:0] REG_PAIR_PRESS       = 3'd4;
    localparam logic [2:0] REG_SLEEP_PRESS      = 3'd5;
    localparam logic [2:0] REG_PAIR_REQUEST_GAP = 3'd6;

    localparam logic [7:0] PAIR_ID_NONE = 8'hFF;

    // LED timing.
    localparam logic [31:0] INIT_BLINK_MS    = 32'd100;
    localparam logic [31:0] PAIRING_BLINK_MS = 32'd500;
    localparam logic [6:0]  SLOT100_LAST     = 7'd99;
    localparam logic [3:0]  DIGIT10_LAST     = 4'd9;
    localparam logic [7:0]  SLOT200_LAST     = 8'd199;
    localparam logic [2:0]  DIGIT6_LAST      = 3'd5;

    typedef struct packed {
        logic [7:0]  stored_pair_id;
        logic [15:0] pair_window_ms;
        logic [15:0] sync_timeout_ms;
        logic [15:0] idle_sleep_ms;
        logic [15:0] pair_press_ms;
        logic [15:0] sleep_press_ms;
        logic [9:0]  pair_request_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic        button_down;
        logic [1:0]  sync_report;
        logic        ack_ok;
        logic [7:0]  offered_id;
        logic        wake_event;
        logic [1:0]  init_status;
    } t_item;

    typedef struct packed {
        logic        led_lit;
        logic [2:0]  mode;
        logic        pair_request;
        logic        save_pairing;
        logic        resync_request;
        logic        sleep_now;
        logic [7:0]  paired_id;
    } t_result;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] ms_count;
        logic [31:0] mode_entry_time;
        logic [31:0] sync_stamp;
        logic [31:0] activity_stamp;
        logic [31:0] led_flip_stamp;
        logic [31:0] pair_req_stamp;
        logic [31:0] press_start_time;
        logic        button_held;
        logic        link_up;
        logic [7:0]  pair_id;
        logic        led;
        // ms_count split into 100 ms slots, the decade digit, 200 ms slots
        // and the digit modulo six, kept in step with ms_count.
        logic [6:0]  slot100;
        logic [3:0]  digit10;
        logic [7:0]  slot200;
        logic [2:0]  digit6;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode: MODE_INIT, ms_count: 32'd0, mode_entry_time: 32'd0,
        sync_stamp: 32'd0, activity_stamp: 32'd0,
        led_flip_stamp: 32'd0, pair_req_stamp: 32'd0,
        press_start_time: 32'd0, button_held: 1'b0, link_up: 1'b0,
        pair_id: PAIR_ID_NONE, led: 1'b1, slot100: 7'd0, digit10: 4'd0,
        slot200: 8'd0, digit6: 3'd0
    };

endpackage

// File: src/tracker_mode_and_led_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker mode and LED sequencer
// Per-tick button, LED and mode control for a wireless motion tracker.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one millisecond tick carrying the
// button level and the radio and wake events. For every tick the block
// returns exactly one request on the master stream: LED level, mode, the
// four action pulses and the current pairing identity.
// A tick is captured in an input register, processed in a single pass of
// combinational logic that updates all timing state, and the result is held
// in an output register, from which it is presented. One tick is accepted
// every cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// input register keeps the next tick, so s_axis_tready falls only when both
// are full.
// Reset puts the block in init mode with the LED lit, the tick counter at
// zero and the identity unpaired; the APB registers return to their defaults.
// The APB registers are to be written only while no tick is in flight; the block does not check this.
// ----------------------------------------------------------------------------
module tracker_mode_and_led_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // button_down[0], sync_report[2:1], ack_ok[3], offered_id[11:4],
    // wake_event[12], init_status[14:13]
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // led_lit[0], mode[3:1], pair_request[4], save_pairing[5],
    // resync_request[6], sleep_now[7], paired_id[15:8]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tmls_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    advance;
    logic    step;
    logic    in_accept;

    tmls_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tmls_step u_step (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.button_down <= s_axis_tdata[0];
            r_in.sync_report <= s_axis_tdata[2:1];
            r_in.ack_ok      <= s_axis_tdata[3];
            r_in.offered_id  <= s_axis_tdata[11:4];
            r_in.wake_event  <= s_axis_tdata[12];
            r_in.init_status <= s_axis_tdata[14:13];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.paired_id, r_out.sleep_now, r_out.resync_request,
                            r_out.save_pairing, r_out.pair_request, r_out.mode,
                            r_out.led_lit};

    // Every processed tick advances the millisecond counter by exactly one.
    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && step) |=> (r_state.ms_count == $past(r_state.ms_count) + 32'd1))
        else $error("tick counter did not advance by one");

    // Entering sleep always leaves the mode in wakeup with the LED dark.
    a_sleep_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sleep_now) |->
            (r_out.mode == MODE_WAKEUP && !r_out.led_lit && !r_out.pair_request))
        else $error("sleep pulse with inconsistent mode or LED");

    // A newly saved identity is never the unpaired marker.
    a_save_paired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.save_pairing) |-> (r_out.paired_id != PAIR_ID_NONE))
        else $error("saved pairing identity is unpaired");

    // The LED phase digits stay within their moduli.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.digit10 <= DIGIT10_LAST) && (r_state.digit6 <= DIGIT6_LAST) &&
        (r_state.slot100 <= SLOT100_LAST) && (r_state.slot200 <= SLOT200_LAST))
        else $error("LED phase counter out of range");

endmodule

// File: src/tmls_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file holding the timing limits and the stored identity.
// ----------------------------------------------------------------------------
module tmls_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output tmls_pkg::t_cfg  o_cfg
);
    import tmls_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stored_pair_id      <= PAIR_ID_NONE;
            r_cfg.pair_window_ms      <= 16'd30000;
            r_cfg.sync_timeout_ms     <= 16'd5000;
            r_cfg.idle_sleep_ms       <= 16'd60000;
            r_cfg.pair_press_ms       <= 16'd5000;
            r_cfg.sleep_press_ms      <= 16'd1000;
            r_cfg.pair_request_gap_ms <= 10'd100;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STORED_PAIR_ID:   r_cfg.stored_pair_id      <= pwdata[7:0];
                REG_PAIRING_TIMEOUT:  r_cfg.pair_window_ms      <= pwdata[15:0];
                REG_SYNC_TIMEOUT:     r_cfg.sync_timeout_ms     <= pwdata[15:0];
                REG_SLEEP_TIMEOUT:    r_cfg.idle_sleep_ms       <= pwdata[15:0];
                REG_PAIR_PRESS:       r_cfg.pair_press_ms       <= pwdata[15:0];
                REG_SLEEP_PRESS:      r_cfg.sleep_press_ms      <= pwdata[15:0];
                REG_PAIR_REQUEST_GAP: r_cfg.pair_request_gap_ms <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STORED_PAIR_ID:   prdata = {24'd0, r_cfg.stored_pair_id};
            REG_PAIRING_TIMEOUT:  prdata = {16'd0, r_cfg.pair_window_ms};
            REG_SYNC_TIMEOUT:     prdata = {16'd0, r_cfg.sync_timeout_ms};
            REG_SLEEP_TIMEOUT:    prdata = {16'd0, r_cfg.idle_sleep_ms};
            REG_PAIR_PRESS:       prdata = {16'd0, r_cfg.pair_press_ms};
            REG_SLEEP_PRESS:      prdata = {16'd0, r_cfg.sleep_press_ms};
            REG_PAIR_REQUEST_GAP: prdata = {22'd0, r_cfg.pair_request_gap_ms};
            default:              prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/tmls_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick step logic
// Combinational next state and result for one millisecond tick.
// ----------------------------------------------------------------------------
module tmls_step (
    input  tmls_pkg::t_state  i_state,
    input  tmls_pkg::t_cfg    i_cfg,
    input  tmls_pkg::t_item   i_item,
    output tmls_pkg::t_state  o_state,
    output tmls_pkg::t_result o_result
);
    import tmls_pkg::*;

    t_state      ns;
    t_result     res;
    logic [31:0] now;
    logic [31:0] dur;

    assign now = i_state.ms_count;

    always_comb begin
        ns  = i_state;
        res = '0;
        dur = now - i_state.press_start_time;

        // Button press and release classification.
        if (i_item.button_down && !ns.button_held) begin
            ns.button_held      = 1'b1;
            ns.press_start_time = now;
        end else if (!i_item.button_down && ns.button_held) begin
            ns.button_held = 1'b0;
            if (dur > {16'd0, i_cfg.pair_press_ms}) begin
                ns.mode            = MODE_PAIRING;
                ns.mode_entry_time = now;
            end else if (dur > {16'd0, i_cfg.sleep_press_ms}) begin
                ns.mode            = MODE_SLEEP;
                ns.mode_entry_time = now;
            end
        end

        // LED pattern for the mode as it stands after the button.
        unique case (ns.mode)
            MODE_INIT: begin
                if (now - ns.led_flip_stamp > INIT_BLINK_MS) begin
                    ns.led            = !ns.led;
                    ns.led_flip_stamp = now;
                end
            end
            MODE_PAIRING: begin
                if (now - ns.led_flip_stamp > PAIRING_BLINK_MS) begin
                    ns.led            = !ns.led;
                    ns.led_flip_stamp = now;
                end
            end
            MODE_SYNCING: ns.led = (i_state.digit10 == 4'd0) || (i_state.digit10 == 4'd2);
            MODE_RUNNING: ns.led = 1'b1;
            MODE_SLEEP, MODE_WAKEUP: ns.led = 1'b0;
            default: ns.led = (i_state.digit6 == 3'd0) || (i_state.digit6 == 3'd2);
        endcase

        // Mode machine.
        unique case (ns.mode)
            MODE_INIT: begin
                ns.pair_id = i_cfg.stored_pair_id;
                if (i_item.init_status == INIT_SENSOR_FAIL) begin
                    ns.mode = MODE_ERROR;
                end else if (ns.pair_id == PAIR_ID_NONE) begin
                    ns.mode = MODE_PAIRING;
                end else if (i_item.init_status != INIT_OK) begin
                    ns.mode = MODE_ERROR;
                end else begin
                    ns.mode = MODE_SYNCING;
                end
                ns.mode_entry_time = now;
                ns.sync_stamp      = now;
                ns.activity_stamp  = now;
            end
            MODE_PAIRING: begin
                if (now - ns.mode_entry_time > {16'd0, i_cfg.pair_window_ms}) begin
                    ns.mode = (ns.pair_id != PAIR_ID_NONE) ? MODE_SYNCING : MODE_ERROR;
                end else begin
                    if (now - ns.pair_req_stamp > {22'd0, i_cfg.pair_request_gap_ms}) begin
                        res.pair_request  = 1'b1;
                        ns.pair_req_stamp = now;
                    end
                    if (i_item.offered_id != PAIR_ID_NONE &&
                        i_item.offered_id != ns.pair_id) begin
                        ns.pair_id         = i_item.offered_id;
                        res.save_pairing   = 1'b1;
                        ns.mode            = MODE_SYNCING;
                        ns.mode_entry_time = now;
                        ns.sync_stamp      = now;
                    end
                end
            end
            MODE_SYNCING: begin
                if (ns.link_up) begin
                    ns.mode            = MODE_RUNNING;
                    ns.mode_entry_time = now;
                end else if (now - ns.mode_entry_time > {16'd0, i_cfg.sync_timeout_ms}) begin
                    res.resync_request = 1'b1;
                    ns.mode_entry_time = now;
                end
            end
            MODE_RUNNING: begin
                if (!ns.link_up &&
                    now - ns.sync_stamp > {16'd0, i_cfg.sync_timeout_ms}) begin
                    ns.mode            = MODE_SYNCING;
                    ns.mode_entry_time = now;
                end
                if (now - ns.activity_stamp > {16'd0, i_cfg.idle_sleep_ms}) begin
                    ns.mode            = MODE_SLEEP;
                    ns.mode_entry_time = now;
                end
            end
            MODE_SLEEP: begin
                ns.led        = 1'b0;
                res.sleep_now = 1'b1;
                ns.mode       = MODE_WAKEUP;
            end
            MODE_WAKEUP: begin
                if (i_item.wake_event) begin
                    if (i_item.init_status == INIT_SENSOR_FAIL) begin
                        ns.mode = MODE_ERROR;
                    end else if (i_item.init_status != INIT_OK &&
                                 ns.pair_id != PAIR_ID_NONE) begin
                        ns.mode = MODE_ERROR;
                    end else begin
                        ns.mode            = MODE_SYNCING;
                        ns.mode_entry_time = now;
                        ns.sync_stamp      = now;
                        ns.activity_stamp  = now;
                    end
                end
            end
            default: ;
        endcase

        // Radio reports are applied last.
        if (i_item.sync_report == SYNC_LOST) begin
            ns.link_up = 1'b0;
        end else if (i_item.sync_report == SYNC_GAINED) begin
            ns.link_up    = 1'b1;
            ns.sync_stamp = now;
            if (ns.mode == MODE_SYNCING) begin
                ns.mode = MODE_RUNNING;
            end
        end
        if (i_item.ack_ok) begin
            ns.activity_stamp = now;
        end

        // Advance the tick counter and its phase digits. When the
        // counter wraps to zero all phases restart with it.
        ns.ms_count = now + 32'd1;
        if (now == '1) begin
            ns.slot100 = 7'd0;
            ns.digit10 = 4'd0;
            ns.slot200 = 8'd0;
            ns.digit6  = 3'd0;
        end else begin
            if (i_state.slot100 == SLOT100_LAST) begin
                ns.slot100 = 7'd0;
                ns.digit10 = (i_state.digit10 == DIGIT10_LAST) ? 4'd0
                                                               : i_state.digit10 + 4'd1;
            end else begin
                ns.slot100 = i_state.slot100 + 7'd1;
            end
            if (i_state.slot200 == SLOT200_LAST) begin
                ns.slot200 = 8'd0;
                ns.digit6  = (i_state.digit6 == DIGIT6_LAST) ? 3'd0
                                                             : i_state.digit6 + 3'd1;
            end else begin
                ns.slot200 = i_state.slot200 + 8'd1;
            end
        end

        res.led_lit   = ns.led;
        res.mode      = ns.mode;
        res.paired_id = ns.pair_id;
    end

    assign o_state  = ns;
    assign o_result = res;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the tracker mode and LED sequencer
// Streams millisecond ticks into the block under a series of register
// settings. A behavioural model of the mode machine, button timing and LED
// patterns predicts every result, and each result is checked field by field.
// Both stream sides stall at random, but the receiver not in the rare-ack phase and neither side at the close.
// ----------------------------------------------------------------------------
module tb_top;
    import tmls_pkg::*;

    localparam logic [1:0]  SYNC_NONE       = 2'd0;
    localparam logic [1:0]  SYNC_RESERVED   = 2'd3;
    localparam logic [1:0]  INIT_RADIO_FAIL = 2'd2;
    localparam logic [1:0]  INIT_RESERVED   = 2'd3;
    localparam logic [31:0] SYNC_SLOT_MS    = 32'd100;
    localparam logic [31:0] SYNC_SLOTS      = 32'd10;
    localparam logic [31:0] ERROR_SLOT_MS   = 32'd200;
    localparam logic [31:0] ERROR_SLOTS     = 32'd6;
    localparam int          PRINT_CAP       = 100;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    tracker_mode_and_led_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Register shadow, starting from the reset values.
    t_cfg cfg_shadow = '{
        stored_pair_id: 8'hFF, pair_window_ms: 16'd30000,
        sync_timeout_ms: 16'd5000, idle_sleep_ms: 16'd60000,
        pair_press_ms: 16'd5000, sleep_press_ms: 16'd1000,
        pair_request_gap_ms: 10'd100
    };

    // Predicted state of the sequencer.
    logic [2:0]  mode_q       = MODE_INIT;
    logic [31:0] tick_now     = '0;
    logic [31:0] mode_since   = '0;
    logic [31:0] sync_seen_at = '0;
    logic [31:0] activity_at  = '0;
    logic [31:0] led_flip_at  = '0;
    logic [31:0] pair_req_at  = '0;
    logic [31:0] press_at     = '0;
    logic        btn_held     = 1'b0;
    logic        link_ok      = 1'b0;
    logic [7:0]  pair_id_q    = PAIR_ID_NONE;
    logic        led_q        = 1'b1;

    t_item   tick_backlog[$];
    t_result due_results[$];
    t_item   held_tick;
    int      fail_count  = 0;

    // Stimulus shaping, changed per phase.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int tx_hold     = 0;
    int rx_hold     = 0;
    int p_sync      = 6;
    int p_ack       = 10;
    int p_offer     = 5;
    int p_wake      = 15;
    int p_fault     = 15;

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (fail_count < PRINT_CAP)
            $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // One millisecond tick of the sequencer: button, LED, mode machine, radio.
    task automatic run_tick(input t_item tk, output t_result res);
        logic [31:0] now;
        logic [31:0] held_for;
        logic [31:0] ph;
        now = tick_now;
        res = '0;

        if (tk.button_down && !btn_held) begin
            btn_held = 1'b1;
            press_at = now;
        end else if (!tk.button_down && btn_held) begin
            held_for = now - press_at;
            btn_held = 1'b0;
            if (held_for > {16'd0, cfg_shadow.pair_press_ms}) begin
                mode_q = MODE_PAIRING;
                mode_since = now;
            end else if (held_for > {16'd0, cfg_shadow.sleep_press_ms}) begin
                mode_q = MODE_SLEEP;
                mode_since = now;
            end
        end

        case (mode_q)
            MODE_INIT: begin
                if (now - led_flip_at > INIT_BLINK_MS) begin
                    led_q = !led_q;
                    led_flip_at = now;
                end
            end
            MODE_PAIRING: begin
                if (now - led_flip_at > PAIRING_BLINK_MS) begin
                    led_q = !led_q;
                    led_flip_at = now;
                end
            end
            MODE_SYNCING: begin
                // Double flash: lit in the first and third 100 ms of each second.
                ph = (now / SYNC_SLOT_MS) % SYNC_SLOTS;
                led_q = (ph == 32'd0) || (ph == 32'd2);
            end
            MODE_RUNNING: led_q = 1'b1;
            MODE_SLEEP, MODE_WAKEUP: led_q = 1'b0;
            default: begin
                ph = (now / ERROR_SLOT_MS) % ERROR_SLOTS;
                led_q = (ph < 32'd3) && !ph[0];
            end
        endcase

        case (mode_q)
            MODE_INIT: begin
                pair_id_q = cfg_shadow.stored_pair_id;
                if (tk.init_status == INIT_SENSOR_FAIL) mode_q = MODE_ERROR;
                else if (pair_id_q == PAIR_ID_NONE) mode_q = MODE_PAIRING;
                else if (tk.init_status != INIT_OK) mode_q = MODE_ERROR;
                else mode_q = MODE_SYNCING;
                mode_since = now;
                sync_seen_at = now;
                activity_at = now;
            end
            MODE_PAIRING: begin
                if (now - mode_since > {16'd0, cfg_shadow.pair_window_ms}) begin
                    mode_q = (pair_id_q != PAIR_ID_NONE) ? MODE_SYNCING : MODE_ERROR;
                end else begin
                    if (now - pair_req_at > {22'd0, cfg_shadow.pair_request_gap_ms}) begin
                        res.pair_request = 1'b1;
                        pair_req_at = now;
                    end
                    if (tk.offered_id != PAIR_ID_NONE && tk.offered_id != pair_id_q) begin
                        pair_id_q = tk.offered_id;
                        res.save_pairing = 1'b1;
                        mode_q = MODE_SYNCING;
                        mode_since = now;
                        sync_seen_at = now;
                    end
                end
            end
            MODE_SYNCING: begin
                if (link_ok) begin
                    mode_q = MODE_RUNNING;
                    mode_since = now;
                end else if (now - mode_since > {16'd0, cfg_shadow.sync_timeout_ms}) begin
                    res.resync_request = 1'b1;
                    mode_since = now;
                end
            end
            MODE_RUNNING: begin
                if (!link_ok && now - sync_seen_at > {16'd0, cfg_shadow.sync_timeout_ms}) begin
                    mode_q = MODE_SYNCING;
                    mode_since = now;
                end
                if (now - activity_at > {16'd0, cfg_shadow.idle_sleep_ms}) begin
                    mode_q = MODE_SLEEP;
                    mode_since = now;
                end
            end
            MODE_SLEEP: begin
                led_q = 1'b0;
                res.sleep_now = 1'b1;
                mode_q = MODE_WAKEUP;
            end
            MODE_WAKEUP: begin
                if (tk.wake_event) begin
                    if (tk.init_status == INIT_SENSOR_FAIL) begin
                        mode_q = MODE_ERROR;
                    end else if (tk.init_status != INIT_OK && pair_id_q != PAIR_ID_NONE) begin
                        mode_q = MODE_ERROR;
                    end else begin
                        mode_q = MODE_SYNCING;
                        mode_since = now;
                        sync_seen_at = now;
                        activity_at = now;
                    end
                end
            end
            default: ;
        endcase

        if (tk.sync_report == SYNC_LOST) begin
            link_ok = 1'b0;
        end else if (tk.sync_report == SYNC_GAINED) begin
            link_ok = 1'b1;
            sync_seen_at = now;
            if (mode_q == MODE_SYNCING) mode_q = MODE_RUNNING;
        end
        if (tk.ack_ok) activity_at = now;
        tick_now = now + 32'd1;

        res.led_lit = led_q;
        res.mode = mode_q;
        res.paired_id = pair_id_q;
    endtask

    // Sender: requests stay valid until taken; gaps only open between requests.
    always @(posedge i_clk) begin : tick_sender
        t_result res;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                run_tick(held_tick, res);
                due_results.push_back(res);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // held until taken
            end else if (tx_hold > 0) begin
                tx_hold--;
                s_axis_tvalid <= 1'b0;
            end else if (tick_backlog.size() != 0 && tx_idle_pct > 0
                         && $urandom_range(0, 99) < tx_idle_pct) begin
                tx_hold = $urandom_range(0, 16);
                s_axis_tvalid <= 1'b0;
            end else if (tick_backlog.size() != 0) begin
                held_tick = tick_backlog.pop_front();
                s_axis_tdata <= {1'b0, held_tick.init_status, held_tick.wake_event,
                                 held_tick.offered_id, held_tick.ack_ok,
                                 held_tick.sync_report, held_tick.button_down};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_checker
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    note_mismatch("unexpected result", {16'd0, m_axis_tdata}, '0);
                end else begin
                    want = due_results.pop_front();
                    if (m_axis_tdata[0] !== want.led_lit)
                        note_mismatch("led_lit", 32'(m_axis_tdata[0]), 32'(want.led_lit));
                    if (m_axis_tdata[3:1] !== want.mode)
                        note_mismatch("mode", 32'(m_axis_tdata[3:1]), 32'(want.mode));
                    if (m_axis_tdata[4] !== want.pair_request)
                        note_mismatch("pair_request", 32'(m_axis_tdata[4]),
                                      32'(want.pair_request));
                    if (m_axis_tdata[5] !== want.save_pairing)
                        note_mismatch("save_pairing", 32'(m_axis_tdata[5]),
                                      32'(want.save_pairing));
                    if (m_axis_tdata[6] !== want.resync_request)
                        note_mismatch("resync_request", 32'(m_axis_tdata[6]),
                                      32'(want.resync_request));
                    if (m_axis_tdata[7] !== want.sleep_now)
                        note_mismatch("sleep_now", 32'(m_axis_tdata[7]), 32'(want.sleep_now));
                    if (m_axis_tdata[15:8] !== want.paired_id)
                        note_mismatch("paired_id", 32'(m_axis_tdata[15:8]),
                                      32'(want.paired_id));
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_hold = $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Write one register, then read it back.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_STORED_PAIR_ID:   cfg_shadow.stored_pair_id = val[7:0];
            REG_PAIRING_TIMEOUT:  cfg_shadow.pair_window_ms = val[15:0];
            REG_SYNC_TIMEOUT:     cfg_shadow.sync_timeout_ms = val[15:0];
            REG_SLEEP_TIMEOUT:    cfg_shadow.idle_sleep_ms = val[15:0];
            REG_PAIR_PRESS:       cfg_shadow.pair_press_ms = val[15:0];
            REG_SLEEP_PRESS:      cfg_shadow.sleep_press_ms = val[15:0];
            REG_PAIR_REQUEST_GAP: cfg_shadow.pair_request_gap_ms = val[9:0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== val) note_mismatch("register readback", prdata, val);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_regs(input int stored_id, input int pairing_to, input int sync_to,
                                input int sleep_to, input int pair_press, input int sleep_press,
                                input int req_gap);
        write_reg(REG_STORED_PAIR_ID, stored_id);
        write_reg(REG_PAIRING_TIMEOUT, pairing_to);
        write_reg(REG_SYNC_TIMEOUT, sync_to);
        write_reg(REG_SLEEP_TIMEOUT, sleep_to);
        write_reg(REG_PAIR_PRESS, pair_press);
        write_reg(REG_SLEEP_PRESS, sleep_press);
        write_reg(REG_PAIR_REQUEST_GAP, req_gap);
    endtask

    task automatic push_tick(input logic btn, input logic [1:0] sync, input logic ack,
                             input logic [7:0] offered, input logic wake,
                             input logic [1:0] status);
        t_item tk;
        tk.button_down = btn;
        tk.sync_report = sync;
        tk.ack_ok = ack;
        tk.offered_id = offered;
        tk.wake_event = wake;
        tk.init_status = status;
        tick_backlog.push_back(tk);
    endtask

    function automatic t_item random_tick(input logic btn);
        t_item tk;
        int r;
        r = $urandom_range(0, 99);
        tk.button_down = btn;
        if (r < p_sync) tk.sync_report = SYNC_LOST;
        else if (r < 2 * p_sync) tk.sync_report = SYNC_GAINED;
        else if (r < 2 * p_sync + 2) tk.sync_report = SYNC_RESERVED;
        else tk.sync_report = SYNC_NONE;
        tk.ack_ok = ($urandom_range(0, 99) < p_ack);
        tk.offered_id = ($urandom_range(0, 99) < p_offer) ? 8'($urandom_range(0, 255))
                                                          : PAIR_ID_NONE;
        tk.wake_event = ($urandom_range(0, 99) < p_wake);
        tk.init_status = ($urandom_range(0, 99) < p_fault) ? 2'($urandom_range(1, 3))
                                                           : INIT_OK;
        return tk;
    endfunction

    // Mostly idle ticks with random radio traffic, plus button presses sized
    // around the current sleep and pairing thresholds.
    task automatic queue_random(input int n);
        int made;
        int hold;
        int sp;
        int pp;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 99) < 4) begin
                sp = int'(cfg_shadow.sleep_press_ms);
                pp = int'(cfg_shadow.pair_press_ms);
                case ($urandom_range(0, 2))
                    0: hold = $urandom_range(1, (sp < 40) ? sp : 40);
                    1: hold = sp + $urandom_range(1, 3);
                    default: hold = pp + $urandom_range(1, 3);
                endcase
                if (hold > 120) hold = $urandom_range(1, 40);
                repeat (hold) tick_backlog.push_back(random_tick(1'b1));
                tick_backlog.push_back(random_tick(1'b0));
                made += hold + 1;
            end else begin
                tick_backlog.push_back(random_tick(1'b0));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (tick_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: init, a sleep press with wakeup, a pairing press
        // and identities at the ends of their range.
        program_regs($urandom_range(0, 1) ? 255 : $urandom_range(0, 254), 20, 8, 12, 6, 3, 2);
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        push_tick(1'b0, SYNC_NONE, 1'b0, PAIR_ID_NONE, 1'b0, 2'($urandom_range(0, 3)));
        push_tick(1'b0, SYNC_RESERVED, 1'b1, 8'h00, 1'b0, INIT_OK);
        push_tick(1'b0, SYNC_GAINED, 1'b0, PAIR_ID_NONE, 1'b0, INIT_OK);
        repeat (4) push_tick(1'b1, SYNC_NONE, 1'b0, PAIR_ID_NONE, 1'b1, INIT_OK);
        push_tick(1'b0, SYNC_NONE, 1'b0, PAIR_ID_NONE, 1'b0, INIT_OK);
        push_tick(1'b0, SYNC_NONE, 1'b0, PAIR_ID_NONE, 1'b1, INIT_RESERVED);
        push_tick(1'b0, SYNC_LOST, 1'b0, PAIR_ID_NONE, 1'b1, INIT_RADIO_FAIL);
        repeat (7) push_tick(1'b1, SYNC_NONE, 1'b0, PAIR_ID_NONE, 1'b0, INIT_OK);
        push_tick(1'b0, SYNC_NONE, 1'b1, PAIR_ID_NONE, 1'b0, INIT_OK);
        push_tick(1'b0, SYNC_NONE, 1'b0, PAIR_ID_NONE, 1'b0, INIT_OK);
        push_tick(1'b0, SYNC_NONE, 1'b0, 8'hAA, 1'b0, INIT_OK);
        push_tick(1'b0, SYNC_GAINED, 1'b1, 8'h55, 1'b0, INIT_SENSOR_FAIL);
        push_tick(1'b0, SYNC_GAINED, 1'b1, PAIR_ID_NONE, 1'b1, INIT_SENSOR_FAIL);
        push_tick(1'b0, SYNC_NONE, 1'b0, 8'h00, 1'b0, INIT_OK);
        // The sender holds off here until every result is back.
        wait_drained();

        program_regs('h3C, 40, 15, 50, 25, 8, 3);
        queue_random(400);
        wait_drained();

        // Smallest settings.
        program_regs(0, 1, 1, 1, 1, 1, 1);
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        queue_random(250);
        wait_drained();

        // Largest timeout and press settings: timeouts and press thresholds never run out.
        program_regs(255, 65535, 65535, 65535, 65535, 65535, 1000);
        tx_idle_pct = 5;
        rx_idle_pct = 5;
        p_offer = 20;
        queue_random(150);
        wait_drained();

        // Pairing threshold below the sleep threshold, and rare acknowledges
        // so that inactivity sleep comes often.
        program_regs('h81, 200, 30, 25, 4, 12, 17);
        tx_idle_pct = 15;
        rx_idle_pct = 0;
        p_ack = 2;
        p_offer = 5;
        queue_random(300);
        wait_drained();

        for (k = 0; k < 3; k++) begin
            program_regs($urandom_range(0, 255), $urandom_range(1, 300), $urandom_range(1, 60),
                         $urandom_range(1, 120), $urandom_range(1, 40), $urandom_range(1, 20),
                         $urandom_range(1, 50));
            tx_idle_pct = $urandom_range(0, 30);
            rx_idle_pct = $urandom_range(0, 30);
            p_sync = $urandom_range(2, 12);
            p_ack = $urandom_range(1, 25);
            p_offer = $urandom_range(2, 15);
            p_wake = $urandom_range(5, 30);
            p_fault = $urandom_range(0, 30);
            queue_random(200);
            wait_drained();
        end

        // Closing stretch at full rate on both sides.
        program_regs($urandom_range(0, 255), $urandom_range(1, 100), $urandom_range(1, 30),
                     $urandom_range(1, 60), $urandom_range(1, 30), $urandom_range(1, 15),
                     $urandom_range(1, 20));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(150);
        wait_drained();

        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// File: sim.f
src/tmls_pkg.sv
src/tmls_cfg_regs.sv
src/tmls_step.sv
src/tracker_mode_and_led_sequencer_unit.sv
sim/tb_top.sv
